// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each use clocks on clk; the first form is gated off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion, also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pcbn_pkg.sv
// ----------------------------------------------------------------------------
// pcbn_pkg
// Types and constants of the per-class box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbn_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  // register indexes of the configuration port
  localparam logic [1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_IDX_MODE      = 2'd1;

  // overlap denominators
  localparam logic [1:0] MODE_UNION   = 2'd0;
  localparam logic [1:0] MODE_SMALLER = 2'd1;
  localparam logic [1:0] MODE_LARGER  = 2'd2;

  localparam logic [15:0] THRESHOLD_RESET = 16'd29491;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0]  class_id;
    logic        last_box;
  } box_in_t;

  typedef struct packed {
    logic [15:0] kept_left;
    logic [15:0] kept_top;
    logic [15:0] kept_width;
    logic [15:0] kept_height;
    logic [7:0]  kept_class;
    logic [5:0]  kept_position;
    logic        overflowed;
    logic        final_result;
  } box_out_t;

  // one entry of the box store
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  cls;
  } box_rec_t;

endpackage

`default_nettype wire

// File: hw/rtl/per_class_box_nms.sv
// Up to 64 boxes are stored as they are taken. After the last box, the suppression pass
// (skipped when the threshold is zero) walks the kept pairs in load order, skips
// pairs of different classes and runs each same-class pair through one shared
// 17x17 multiplier (4 products per pair), then hands each surviving box to the
// output register and steps past each dropped box; results can stall on out_ready.
// Throughput: one list at a time; in_ready is low from the last box to the end.
// Reset (synchronous, rst_n low): empty list, threshold 29491, mode union.
// ----------------------------------------------------------------------------
// per_class_box_nms
// Greedy per-class non-maximum suppression over a list of stored boxes.
// ----------------------------------------------------------------------------
`default_nettype none

module per_class_box_nms
  import pcbn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // input transactions: one box each
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire box_in_t  in_data,
  // result transactions: one surviving box each
  output logic          out_valid,
  input  wire logic     out_ready,
  output box_out_t      out_data,
  // configuration writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Sequencer states
  localparam logic [3:0] ST_LOAD  = 4'd0;  // take boxes
  localparam logic [3:0] ST_OUTER = 4'd1;  // pick the next kept box i
  localparam logic [3:0] ST_RDA   = 4'd2;  // latch box i, area of box i
  localparam logic [3:0] ST_INNER = 4'd3;  // pick the next kept box j
  localparam logic [3:0] ST_SPAN  = 4'd4;  // class check, spans, area of box j
  localparam logic [3:0] ST_INTER = 4'd5;  // intersection product
  localparam logic [3:0] ST_DEN   = 4'd6;  // denominator select
  localparam logic [3:0] ST_MLO   = 4'd7;  // threshold times low half of den
  localparam logic [3:0] ST_MHI   = 4'd8;  // threshold times high half, sum
  localparam logic [3:0] ST_CMP   = 4'd9;  // compare, drop box j
  localparam logic [3:0] ST_ESCAN = 4'd10; // pick the next survivor
  localparam logic [3:0] ST_EOUT  = 4'd11; // hand survivor to output register

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_BOXES);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  // Control registers
  logic [3:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MAX_BOXES-1:0] keep_r, keep_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic [15:0]          thr_r, thr_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Datapath registers
  box_rec_t    a_r, a_nxt;          // the suppressing box i
  logic [31:0] area_a_r, area_a_nxt;
  logic [31:0] area_b_r, area_b_nxt;
  logic [15:0] span_w_r, span_w_nxt;
  logic [15:0] span_h_r, span_h_nxt;
  logic        ovl_r, ovl_nxt;      // both spans non-negative
  logic [31:0] inter_r, inter_nxt;
  logic [32:0] den_r, den_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic [48:0] rhs_r, rhs_nxt;
  box_out_t    out_data_r, out_data_nxt;

  // Box store: one write port (loading), one registered read port
  box_rec_t             mem [MAX_BOXES];
  box_rec_t             rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  box_rec_t             mem_wdata;

  // Shared multiplier
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;

  // Span logic of the pair (box i in a_r, box j on the read port)
  logic [16:0] a_right, a_bottom, b_right, b_bottom;
  logic [16:0] hi_w, hi_h;
  logic [15:0] lo_w, lo_h;

  logic later_kept;
  logic out_free;

  assign in_ready  = (state_r == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign mul_p = 34'(mul_a) * 34'(mul_b);

  // Read address follows the scan counter in use
  always_comb begin
    if (state_r == ST_OUTER) begin
      rd_addr = i_r[IDX_W-1:0];
    end else begin
      rd_addr = j_r[IDX_W-1:0];
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_RDA, ST_SPAN: begin
        mul_a = {1'b0, rd_data_r.width};
        mul_b = {1'b0, rd_data_r.height};
      end
      ST_INTER: begin
        mul_a = {1'b0, span_w_r};
        mul_b = {1'b0, span_h_r};
      end
      ST_MLO: begin
        mul_a = {1'b0, thr_r};
        mul_b = den_r[16:0];
      end
      ST_MHI: begin
        mul_a = {1'b0, thr_r};
        mul_b = {1'b0, den_r[32:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Overlap spans; right and bottom edges in 17 bits, no wrap
  always_comb begin
    a_right  = {1'b0, a_r.left} + {1'b0, a_r.width};
    a_bottom = {1'b0, a_r.top} + {1'b0, a_r.height};
    b_right  = {1'b0, rd_data_r.left} + {1'b0, rd_data_r.width};
    b_bottom = {1'b0, rd_data_r.top} + {1'b0, rd_data_r.height};
    hi_w = (a_right < b_right) ? a_right : b_right;
    hi_h = (a_bottom < b_bottom) ? a_bottom : b_bottom;
    lo_w = (a_r.left > rd_data_r.left) ? a_r.left : rd_data_r.left;
    lo_h = (a_r.top > rd_data_r.top) ? a_r.top : rd_data_r.top;
  end

  // Is any box after the current survivor still kept? Marks the final result.
  always_comb begin
    later_kept = 1'b0;
    for (int b = 0; b < MAX_BOXES; b++) begin
      if (keep_r[b] && (CNT_W'(b) > j_r) && (CNT_W'(b) < count_r)) begin
        later_kept = 1'b1;
      end
    end
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    keep_nxt      = keep_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    thr_nxt       = thr_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r;
    a_nxt         = a_r;
    area_a_nxt    = area_a_r;
    area_b_nxt    = area_b_r;
    span_w_nxt    = span_w_r;
    span_h_nxt    = span_h_r;
    ovl_nxt       = ovl_r;
    inter_nxt     = inter_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    rhs_nxt       = rhs_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = '{left: in_data.box_left, top: in_data.box_top,
                      width: in_data.box_width, height: in_data.box_height,
                      cls: in_data.class_id};

    // Drop the result once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes; unknown indexes are ignored
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_THRESHOLD: thr_nxt = cfg_data;
        CFG_IDX_MODE:      mode_nxt = cfg_data[1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (count_r < CAP) begin
            mem_we    = 1'b1;
            count_nxt = count_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_box) begin
            i_nxt = '0;
            j_nxt = '0;
            if (thr_r == '0) begin
              state_nxt = ST_ESCAN;
            end else begin
              state_nxt = ST_OUTER;
            end
          end
        end
      end

      ST_OUTER: begin
        if ((i_r + ONE) >= count_r) begin
          j_nxt     = '0;
          state_nxt = ST_ESCAN;
        end else if (!keep_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + ONE;
        end else begin
          state_nxt = ST_RDA;
        end
      end

      ST_RDA: begin
        a_nxt      = rd_data_r;
        area_a_nxt = mul_p[31:0];
        j_nxt      = i_r + ONE;
        state_nxt  = ST_INNER;
      end

      ST_INNER: begin
        if (j_r >= count_r) begin
          i_nxt     = i_r + ONE;
          state_nxt = ST_OUTER;
        end else if (!keep_r[j_r[IDX_W-1:0]]) begin
          j_nxt = j_r + ONE;
        end else begin
          state_nxt = ST_SPAN;
        end
      end

      ST_SPAN: begin
        if (rd_data_r.cls != a_r.cls) begin
          j_nxt     = j_r + ONE;
          state_nxt = ST_INNER;
        end else begin
          area_b_nxt = mul_p[31:0];
          ovl_nxt    = (hi_w >= {1'b0, lo_w}) && (hi_h >= {1'b0, lo_h});
          span_w_nxt = 16'(hi_w - {1'b0, lo_w});
          span_h_nxt = 16'(hi_h - {1'b0, lo_h});
          state_nxt  = ST_INTER;
        end
      end

      ST_INTER: begin
        inter_nxt = ovl_r ? mul_p[31:0] : '0;
        state_nxt = ST_DEN;
      end

      ST_DEN: begin
        case (mode_r)
          MODE_SMALLER: den_nxt = {1'b0, (area_a_r < area_b_r) ? area_a_r : area_b_r};
          MODE_LARGER:  den_nxt = {1'b0, (area_a_r > area_b_r) ? area_a_r : area_b_r};
          default:      den_nxt = {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, inter_r};
        endcase
        state_nxt = ST_MLO;
      end

      ST_MLO: begin
        acc_nxt   = mul_p[32:0];
        state_nxt = ST_MHI;
      end

      ST_MHI: begin
        rhs_nxt   = {mul_p[31:0], 17'd0} + {16'd0, acc_r};
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        if ({2'b00, inter_r, 15'd0} > rhs_r) begin
          keep_nxt[j_r[IDX_W-1:0]] = 1'b0;
        end
        j_nxt     = j_r + ONE;
        state_nxt = ST_INNER;
      end

      ST_ESCAN: begin
        if (j_r >= count_r) begin
          // list done: clear for the next one
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          keep_nxt  = '1;
          state_nxt = ST_LOAD;
        end else if (!keep_r[j_r[IDX_W-1:0]]) begin
          j_nxt = j_r + ONE;
        end else begin
          state_nxt = ST_EOUT;
        end
      end

      ST_EOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kept_left: rd_data_r.left, kept_top: rd_data_r.top,
                            kept_width: rd_data_r.width, kept_height: rd_data_r.height,
                            kept_class: rd_data_r.cls, kept_position: 6'(j_r),
                            overflowed: ovf_r, final_result: !later_kept};
          j_nxt     = j_r + ONE;
          state_nxt = ST_ESCAN;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      keep_r      <= '1;
      i_r         <= '0;
      j_r         <= '0;
      thr_r       <= THRESHOLD_RESET;
      mode_r      <= MODE_UNION;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      keep_r      <= keep_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      thr_r       <= thr_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    area_a_r   <= area_a_nxt;
    area_b_r   <= area_b_nxt;
    span_w_r   <= span_w_nxt;
    span_h_r   <= span_h_nxt;
    ovl_r      <= ovl_nxt;
    inter_r    <= inter_nxt;
    den_r      <= den_nxt;
    acc_r      <= acc_nxt;
    rhs_r      <= rhs_nxt;
    out_data_r <= out_data_nxt;
  end

  // Box store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/pcbn_checker.sv
// ----------------------------------------------------------------------------
// pcbn_checker
// Port-level checks of the box suppression block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcbn_checker
  import pcbn_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire box_in_t     in_data,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire box_out_t    out_data
);

  // A stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // A box that is not last leaves the block ready for the next one
  `ASSERT_CLK(a_load_ready, in_valid && in_ready && !in_data.last_box |=> in_ready, "not ready during loading")

  // The last box ends loading: no box is taken in the next cycle
  `ASSERT_CLK(a_pass_busy, in_valid && in_ready && in_data.last_box |=> !in_ready, "ready right after last box")

  // An offered result carries a fully known payload
  `ASSERT_CLK(a_out_known, out_valid |-> !$isunknown(out_data), "unknown bits in result")

endmodule

bind per_class_box_nms pcbn_checker u_pcbn_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-class box suppression block.
// Box lists are streamed in over valid/ready with bursty gaps while the result
// side stalls on its own pattern. A behavioral predictor keeps its own box
// store and keep flags, runs the greedy same-class suppression on every closed
// list with a nonzero threshold and queues the surviving boxes; each result
// transaction is compared field by field against the oldest queued survivor.
// ----------------------------------------------------------------------------

module tb;
  import pcbn_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  // idle cycles after the last survivor before touching registers or ending
  localparam int SETTLE_CYCLES = 40;

  // indexes with no register behind them, and the spare mode code
  localparam logic [1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE3 = 2'd3;
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  box_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  box_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #2 clk = ~clk;

  per_class_box_nms DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the box store, keep flags and registers
  // --------------------------------------------------------------------------
  box_rec_t    held_box [MAX_BOXES];
  bit          keep     [MAX_BOXES];
  int          held_count = 0;
  bit          held_overflow = 1'b0;
  logic [15:0] thr_q = THRESHOLD_RESET;
  logic [1:0]  mode_q = MODE_UNION;

  // survivors predicted but not yet seen on the result port
  box_out_t    survivors_due [$];

  int error_count = 0;
  int cycle_count = 0;
  int boxes_loaded = 0;
  int boxes_dropped = 0;
  int lists_closed = 0;
  int boxes_suppressed = 0;
  int survivors_seen = 0;
  int burst_left = 0;

  initial begin
    for (int i = 0; i < MAX_BOXES; i++) keep[i] = 1'b1;
  end

  // Overlap on one axis: min of the far edges minus max of the near edges.
  // Far edges are 17 bits wide so left + width never wraps.
  function automatic longint axis_overlap(input logic [15:0] p1, s1, p2, s2);
    logic [16:0] e1, e2, lo, hi;
    longint      hi_v, lo_v;
    e1 = {1'b0, p1} + {1'b0, s1};
    e2 = {1'b0, p2} + {1'b0, s2};
    lo = (p1 > p2) ? {1'b0, p1} : {1'b0, p2};
    hi = (e1 < e2) ? e1 : e2;
    hi_v = hi;
    lo_v = lo;
    return hi_v - lo_v;
  endfunction

  // True when box a overlaps box b strictly more than the threshold allows.
  // Cross-multiply: I * 2^15 > threshold * D, all in 64 bits.
  function automatic bit overlaps_too_much(input box_rec_t a, input box_rec_t b);
    longint          span_x, span_y;
    longint unsigned inter, area_a, area_b, den, lhs, rhs;
    span_x = axis_overlap(a.left, a.width, b.left, b.width);
    span_y = axis_overlap(a.top, a.height, b.top, b.height);
    inter  = 0;
    area_a = longint'(a.width) * longint'(a.height);
    area_b = longint'(b.width) * longint'(b.height);
    if (span_x >= 0 && span_y >= 0) inter = span_x * span_y;
    case (mode_q)
      MODE_SMALLER: den = (area_a < area_b) ? area_a : area_b;
      MODE_LARGER:  den = (area_a > area_b) ? area_a : area_b;
      default:      den = area_a + area_b - inter;
    endcase
    lhs = inter << 15;
    rhs = den * longint'(thr_q);
    return lhs > rhs;
  endfunction

  // Store one accepted box; on the closing box run greedy per-class suppression
  // unless the threshold is zero, queue the survivors in load order, clear the list.
  function automatic void load_and_suppress(input box_in_t b);
    int       last_kept;
    box_out_t r;
    boxes_loaded++;
    if (held_count < MAX_BOXES) begin
      held_box[held_count] = '{b.box_left, b.box_top, b.box_width, b.box_height,
                               b.class_id};
      held_count++;
    end else begin
      held_overflow = 1'b1;
      boxes_dropped++;
    end
    if (b.last_box) begin
      lists_closed++;
      if (thr_q != 0) begin
        for (int i = 0; i < held_count; i++) begin
          if (keep[i]) begin
            for (int j = i + 1; j < held_count; j++) begin
              if (keep[j] && held_box[i].cls == held_box[j].cls &&
                  overlaps_too_much(held_box[i], held_box[j]))
                keep[j] = 1'b0;
            end
          end
        end
      end
      last_kept = 0;
      for (int i = 0; i < held_count; i++) if (keep[i]) last_kept = i;
      for (int i = 0; i < held_count; i++) begin
        if (keep[i]) begin
          r.kept_left     = held_box[i].left;
          r.kept_top      = held_box[i].top;
          r.kept_width    = held_box[i].width;
          r.kept_height   = held_box[i].height;
          r.kept_class    = held_box[i].cls;
          r.kept_position = 6'(i);
          r.overflowed    = held_overflow;
          r.final_result  = (i == last_kept);
          survivors_due.push_back(r);
        end else begin
          boxes_suppressed++;
        end
      end
      for (int i = 0; i < MAX_BOXES; i++) keep[i] = 1'b1;
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every accepted result transaction against the oldest
  // queued survivor
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    box_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (survivors_due.size() == 0) begin
        $display("%0t ERROR result with none pending: expected none, actual %h",
                 $time, out_data);
        error_count++;
      end else begin
        want = survivors_due.pop_front();
        survivors_seen++;
        check_field("kept_left",     want.kept_left,     out_data.kept_left);
        check_field("kept_top",      want.kept_top,      out_data.kept_top);
        check_field("kept_width",    want.kept_width,    out_data.kept_width);
        check_field("kept_height",   want.kept_height,   out_data.kept_height);
        check_field("kept_class",    16'(want.kept_class), 16'(out_data.kept_class));
        check_field("kept_position", 16'(want.kept_position),
                    16'(out_data.kept_position));
        check_field("overflowed",    16'(want.overflowed), 16'(out_data.overflowed));
        check_field("final_result",  16'(want.final_result),
                    16'(out_data.final_result));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side back-pressure and run limit. The acceptance rate is redrawn
  // from 100, 70, 35 or 10 percent; 100 percent gives stretches with no stall at all.
  // --------------------------------------------------------------------------
  int ready_pct = 100;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 70;
        2:       ready_pct = 35;
        default: ready_pct = 10;
      endcase
    end
    out_ready <= ($urandom_range(1, 100) <= ready_pct);
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus helpers; the tasks start and end on a rising edge
  // --------------------------------------------------------------------------
  function automatic box_in_t mk_box(input logic [15:0] l, t, w, h,
                                     input logic [7:0] c, input logic is_last);
    box_in_t b;
    b.box_left   = l;
    b.box_top    = t;
    b.box_width  = w;
    b.box_height = h;
    b.class_id   = c;
    b.last_box   = is_last;
    return b;
  endfunction

  // Send one box transaction. Boxes go out in bursts of random length; between
  // bursts drop valid for a random gap (sometimes none).
  task automatic send_box(input box_in_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    load_and_suppress(b);
  endtask

  // Release the input, wait for every queued survivor, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (survivors_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold cfg_valid high through the write; the caller releases it.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IDX_THRESHOLD: thr_q = data;
      CFG_IDX_MODE:      mode_q = data[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [15:0] mode);
    wait_drained();
    write_reg(CFG_IDX_THRESHOLD, thr);
    write_reg(CFG_IDX_MODE, mode);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All-ones boxes whose far edges need the 17th bit (identical, so the second
  // goes), then zero-area boxes where the denominator is zero and both stay.
  task automatic test_extreme_fields();
    send_box(mk_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0));
    send_box(mk_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
    send_box(mk_box(0, 0, 0, 0, 0, 1'b0));
    send_box(mk_box(0, 0, 0, 0, 0, 1'b1));
  endtask

  // Same pair under every denominator: I = 2500, union 12500, smaller 5000,
  // larger 10000. At 0.375 only the smaller-area mode drops the second box;
  // at exactly 0.5 the strict compare keeps it.
  task automatic test_overlap_modes();
    logic [1:0] modes [4];
    modes = '{MODE_UNION, MODE_SMALLER, MODE_LARGER, MODE_SPARE};
    for (int m = 0; m < 4; m++) begin
      set_config(16'h3000, {14'd0, modes[m]});
      send_box(mk_box(0, 0, 100, 100, 5, 1'b0));
      send_box(mk_box(50, 0, 100, 50, 5, 1'b1));
    end
    set_config(16'h4000, {14'd0, MODE_SMALLER});
    send_box(mk_box(0, 0, 100, 100, 5, 1'b0));
    send_box(mk_box(50, 0, 100, 50, 5, 1'b1));
  endtask

  // Zero threshold keeps everything, the smallest threshold drops on a single
  // unit of overlap, the largest never drops; writes to unused indexes must
  // not disturb the threshold or mode.
  task automatic test_thresholds();
    set_config(16'h0000, {14'd0, MODE_UNION});
    send_box(mk_box(200, 200, 100, 100, 9, 1'b0));
    send_box(mk_box(200, 200, 100, 100, 9, 1'b1));
    set_config(16'h0001, {14'd0, MODE_UNION});
    send_box(mk_box(0, 0, 100, 100, 9, 1'b0));
    send_box(mk_box(99, 99, 100, 100, 9, 1'b1));
    set_config(16'hFFFF, {14'd0, MODE_UNION});
    send_box(mk_box(200, 200, 100, 100, 9, 1'b0));
    send_box(mk_box(200, 200, 100, 100, 9, 1'b1));
    set_config(THRESHOLD_RESET, {14'd0, MODE_UNION});
    wait_drained();
    write_reg(CFG_IDX_SPARE2, 16'h0000);
    write_reg(CFG_IDX_SPARE3, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_box(mk_box(200, 200, 100, 100, 9, 1'b0));
    send_box(mk_box(200, 200, 100, 100, 9, 1'b1));
  endtask

  // A drops B; B would drop C but is already gone, so C stays. D matches A
  // exactly but has another class. E sits far away.
  task automatic test_class_and_chain();
    set_config(16'h1000, {14'd0, MODE_UNION});
    send_box(mk_box(0, 0, 100, 100, 1, 1'b0));
    send_box(mk_box(60, 0, 100, 100, 1, 1'b0));
    send_box(mk_box(120, 0, 100, 100, 1, 1'b0));
    send_box(mk_box(0, 0, 100, 100, 2, 1'b0));
    send_box(mk_box(1000, 1000, 10, 10, 1, 1'b1));
  endtask

  // Fill the store and push two more; the closing box itself is dropped, yet
  // suppression still runs over the stored boxes and every result is flagged.
  task automatic test_capacity();
    box_in_t b;
    set_config(16'h4000, {14'd0, MODE_UNION});
    for (int k = 0; k < MAX_BOXES + 2; k++) begin
      b.box_left   = 16'($urandom_range(0, 2000));
      b.box_top    = 16'($urandom_range(0, 2000));
      b.box_width  = 16'($urandom_range(200, 400));
      b.box_height = 16'($urandom_range(200, 400));
      b.class_id   = 8'($urandom_range(0, 1));
      b.last_box   = (k == MAX_BOXES + 1);
      send_box(b);
    end
  endtask

  // Random lists. Mostly tight clusters of a few classes, so boxes really
  // compete; the rest are fully random or near-degenerate (often zero width or height).
  task automatic test_random_lists(input int budget);
    int          sent, len, style;
    logic [15:0] cx, cy, thr, mode;
    box_in_t     b;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       thr = 16'h0000;
          1:       thr = 16'h0001;
          2:       thr = 16'hFFFF;
          3:       thr = 16'($urandom_range(0, 65535));
          default: thr = 16'($urandom_range(16'h2000, 16'h7000));
        endcase
        mode = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 3));
        set_config(thr, mode);
      end
      len   = $urandom_range(1, 10);
      style = $urandom_range(0, 4);
      cx    = 16'($urandom_range(0, 16'hF000));
      cy    = 16'($urandom_range(0, 16'hF000));
      for (int k = 0; k < len; k++) begin
        case (style)
          3: begin
            b.box_left   = 16'($urandom_range(0, 65535));
            b.box_top    = 16'($urandom_range(0, 65535));
            b.box_width  = 16'($urandom_range(0, 65535));
            b.box_height = 16'($urandom_range(0, 65535));
            b.class_id   = 8'($urandom_range(0, 255));
          end
          4: begin
            b.box_left   = cx + 16'($urandom_range(0, 40));
            b.box_top    = cy + 16'($urandom_range(0, 40));
            b.box_width  = ($urandom_range(0, 1) == 0) ? 16'd0
                                                       : 16'($urandom_range(1, 80));
            b.box_height = ($urandom_range(0, 1) == 0) ? 16'd0
                                                       : 16'($urandom_range(1, 80));
            b.class_id   = 8'd0;
          end
          default: begin
            b.box_left   = cx + 16'($urandom_range(0, 48));
            b.box_top    = cy + 16'($urandom_range(0, 48));
            b.box_width  = 16'($urandom_range(160, 320));
            b.box_height = 16'($urandom_range(160, 320));
            b.class_id   = 8'($urandom_range(0, 2));
          end
        endcase
        b.last_box = (k == len - 1);
        send_box(b);
      end
      sent += len;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_extreme_fields();
    test_overlap_modes();
    test_thresholds();
    test_class_and_chain();
    test_capacity();
    test_random_lists(77);

    // Drain the last list and give the block time to go quiet.
    wait_drained();

    $display("Ran %0d box lists: %0d boxes loaded, %0d dropped at capacity.",
             lists_closed, boxes_loaded, boxes_dropped);
    $display("Checked %0d surviving boxes; %0d boxes suppressed across all modes.",
             survivors_seen, boxes_suppressed);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
